// ----- rtl/tst_pkg.sv -----
// Package for the task slot table: command and status codes and beat field widths.
package tst_pkg;

    // Command codes carried on the slave-side tuser
    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_LIST    = 2'd3
    } cmd_t;

    // Status codes carried on the master-side tuser
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Beat field widths
    localparam int TASK_ID_W   = 16;
    localparam int RESULT_ID_W = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int M_TDATA_W   = 24;
    localparam int M_PAD_W     = M_TDATA_W - RESULT_ID_W - SLOT_OUT_W;

endpackage

// ----- rtl/task_slot_table_core.sv -----
// Task slot table: create, destroy, find and list tasks held in a slot memory.
// Create answers straight from its command beat; destroy and find walk the slots with a read
// and an evaluate state per slot, and list gives one beat for each used slot.
// One command is handled at a time; the slot walk through the id memory paces destroy, find and list.
// A new command is taken while the last result beat still waits on the master side.
// Reset (aresetn low, synchronous) clears the used flags, the id counter and the output beat.
module task_slot_table_core #(
    parameter int NUM_SLOTS = 12,
    parameter int ID_WIDTH  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Command channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [tst_pkg::TASK_ID_W-1:0]          s_tdata,   // [15:0] task_id
    input  logic [1:0]                             s_tuser,   // [1:0] cmd
    // Result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [tst_pkg::M_TDATA_W-1:0]          m_tdata,   // [15:0] result_id, [19:16] slot
    output logic [1:0]                             m_tuser,   // [1:0] status
    output logic                                   m_tlast    // last
);
    import tst_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    cmd_t                      cmd_reg;
    logic [NUM_SLOTS-1:0]      used_reg;
    logic [ID_WIDTH-1:0]       counter_reg;
    logic [ID_WIDTH-1:0]       want_reg;
    logic [SLOT_W-1:0]         ptr_reg;
    logic [ID_WIDTH-1:0]       rd_data_reg;
    status_t                   pend_status_reg;
    logic [ID_WIDTH-1:0]       pend_id_reg;
    logic [SLOT_W-1:0]         pend_slot_reg;
    logic                      m_valid_reg;
    status_t                   m_status_reg;
    logic [RESULT_ID_W-1:0]    m_id_reg;
    logic [SLOT_OUT_W-1:0]     m_slot_reg;
    logic                      m_last_reg;

    logic [ID_WIDTH-1:0]       id_mem [NUM_SLOTS];

    logic [ID_WIDTH-1:0]       counter_inc;
    logic [ID_WIDTH-1:0]       want_in;
    logic [31:0]               task_id_wide;
    logic                      free_found;
    logic [SLOT_W-1:0]         free_idx;
    logic                      more_above;
    logic                      hit;
    logic                      out_free;
    logic                      accept;
    logic                      mem_we;
    logic                      load_beat;
    logic                      m_valid_next;

    // Fit an id to the result field
    function automatic logic [RESULT_ID_W-1:0] out_id(input logic [ID_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[RESULT_ID_W-1:0];
    endfunction

    // Fit a slot index to the result field
    function automatic logic [SLOT_OUT_W-1:0] out_slot(input logic [SLOT_W-1:0] v);
        logic [7:0] w;
        w = 8'(v);
        return w[SLOT_OUT_W-1:0];
    endfunction

    // Handshake and masked command inputs
    assign s_tready     = (state_reg == ST_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign out_free     = !m_valid_reg || m_tready;
    assign counter_inc  = counter_reg + ID_WIDTH'(1);
    assign task_id_wide = 32'(s_tdata);
    assign want_in      = task_id_wide[ID_WIDTH-1:0];
    assign mem_we       = accept && (cmd_t'(s_tuser) == CMD_CREATE) && free_found;
    assign hit          = used_reg[ptr_reg] && (rd_data_reg == want_reg);

    // Load a result beat when the output register is free
    assign load_beat    = out_free && ((state_reg == ST_EMIT) ||
                          ((state_reg == ST_EVAL) &&
                           ((cmd_reg == CMD_LIST) ? used_reg[ptr_reg] : hit)));
    assign m_valid_next = load_beat || (m_valid_reg && !m_tready);

    // Find the lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Check for a used slot above the walk pointer
    always_comb begin
        more_above = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (used_reg[i] && (SLOT_W'(i) > ptr_reg)) begin
                more_above = 1'b1;
            end
        end
    end

    // Id memory: write on create, read at the walk pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            id_mem[free_idx] <= counter_inc;
        end
        rd_data_reg <= id_mem[ptr_reg];
    end

    // Command sequencer and output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Hold, drop or load the output beat
            m_valid_reg <= m_valid_next;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg  <= cmd_t'(s_tuser);
                        want_reg <= want_in;
                        ptr_reg  <= '0;
                        unique case (cmd_t'(s_tuser))
                            CMD_CREATE: begin
                                counter_reg <= counter_inc;
                                if (free_found) begin
                                    used_reg[free_idx] <= 1'b1;
                                    pend_status_reg    <= STAT_OK;
                                    pend_id_reg        <= counter_inc;
                                    pend_slot_reg      <= free_idx;
                                end else begin
                                    pend_status_reg <= STAT_FULL;
                                    pend_id_reg     <= '0;
                                    pend_slot_reg   <= '0;
                                end
                                state_reg <= ST_EMIT;
                            end
                            CMD_DESTROY, CMD_FIND: begin
                                state_reg <= ST_READ;
                            end
                            CMD_LIST: begin
                                if (used_reg == '0) begin
                                    pend_status_reg <= STAT_EMPTY;
                                    pend_id_reg     <= '0;
                                    pend_slot_reg   <= '0;
                                    state_reg       <= ST_EMIT;
                                end else begin
                                    state_reg <= ST_READ;
                                end
                            end
                        endcase
                    end
                end

                // Wait for the id memory read
                ST_READ: begin
                    state_reg <= ST_EVAL;
                end

                ST_EVAL: begin
                    if (cmd_reg == CMD_LIST) begin
                        // Emit each used slot, skip the rest
                        if (used_reg[ptr_reg]) begin
                            if (out_free) begin
                                m_status_reg <= STAT_OK;
                                m_id_reg     <= out_id(rd_data_reg);
                                m_slot_reg   <= out_slot(ptr_reg);
                                m_last_reg   <= !more_above;
                                if (more_above) begin
                                    ptr_reg   <= ptr_reg + SLOT_W'(1);
                                    state_reg <= ST_READ;
                                end else begin
                                    state_reg <= ST_IDLE;
                                end
                            end
                        end else begin
                            ptr_reg   <= ptr_reg + SLOT_W'(1);
                            state_reg <= ST_READ;
                        end
                    end else if (hit) begin
                        // Report the match, clear it on destroy
                        if (out_free) begin
                            m_status_reg <= STAT_OK;
                            m_id_reg     <= '0;
                            m_slot_reg   <= out_slot(ptr_reg);
                            m_last_reg   <= 1'b1;
                            if (cmd_reg == CMD_DESTROY) begin
                                used_reg[ptr_reg] <= 1'b0;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end else if (ptr_reg == LAST_SLOT) begin
                        pend_status_reg <= STAT_NOT_FOUND;
                        pend_id_reg     <= '0;
                        pend_slot_reg   <= '0;
                        state_reg       <= ST_EMIT;
                    end else begin
                        ptr_reg   <= ptr_reg + SLOT_W'(1);
                        state_reg <= ST_READ;
                    end
                end

                // Send the single pending beat
                ST_EMIT: begin
                    if (out_free) begin
                        m_status_reg <= pend_status_reg;
                        m_id_reg     <= out_id(pend_id_reg);
                        m_slot_reg   <= out_slot(pend_slot_reg);
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Drive the result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_slot_reg, m_id_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- tb/task_slot_table_core_test.sv -----
// Self-checking testbench for the task slot table core: predicts slot table results beat by beat.
`timescale 1ns / 1ps

module task_slot_table_core_test;
    import tst_pkg::*;

    localparam int SLOTS = 12;

    typedef struct {
        cmd_t        op;
        logic [15:0] id;
        int unsigned gap;
        bit          drain;
    } cmd_item_t;

    typedef struct {
        status_t     status;
        logic [15:0] rid;
        logic [3:0]  slot;
        logic        last;
    } table_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [15:0] task_id
    logic [1:0]  s_tuser = '0;      // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [15:0] result_id, [19:16] slot
    logic [1:0]  m_tuser;           // [1:0] status
    logic        m_tlast;

    // Command stream and expected result beats
    cmd_item_t   cmd_queue[$];
    table_beat_t owed_beats[$];

    // Shadow of the slot table
    logic        shadow_used[SLOTS];
    logic [15:0] shadow_id[SLOTS];
    logic [15:0] serial_ctr;

    // Driver state
    cmd_item_t   nxt;
    int unsigned idle_left = 0;
    bit          gap_taken = 1'b0;

    // Monitor state
    int unsigned rx_left = 0;
    bit          rx_idle_on = 1'b1;
    bit          all_answered = 1'b1;
    int          faults = 0;
    int          beats_seen = 0;
    int          cmd_seen[4] = '{0, 0, 0, 0};
    table_beat_t got;
    table_beat_t want;

    // Generator bookkeeping
    logic [15:0] gen_ctr = '0;
    bit          burst_mode;
    int          pick;

    task_slot_table_core #(
        .NUM_SLOTS (SLOTS),
        .ID_WIDTH  (16)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Apply one command to the shadow table and queue the beats it owes
    task automatic table_apply(input cmd_t op, input logic [15:0] key);
        int hit;
        int top;
        table_beat_t b;
        hit = -1;
        top = -1;
        case (op)
            CMD_CREATE: begin
                serial_ctr = serial_ctr + 16'd1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0 && !shadow_used[i]) hit = i;
                end
                if (hit < 0) begin
                    b = '{STAT_FULL, 16'd0, 4'd0, 1'b1};
                end else begin
                    shadow_used[hit] = 1'b1;
                    shadow_id[hit] = serial_ctr;
                    b = '{STAT_OK, serial_ctr, 4'(hit), 1'b1};
                end
                owed_beats.push_back(b);
            end
            CMD_DESTROY, CMD_FIND: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0 && shadow_used[i] && shadow_id[i] == key) hit = i;
                end
                if (hit < 0) begin
                    b = '{STAT_NOT_FOUND, 16'd0, 4'd0, 1'b1};
                end else begin
                    if (op == CMD_DESTROY) shadow_used[hit] = 1'b0;
                    b = '{STAT_OK, 16'd0, 4'(hit), 1'b1};
                end
                owed_beats.push_back(b);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_used[i]) top = i;
                end
                if (top < 0) begin
                    owed_beats.push_back('{STAT_EMPTY, 16'd0, 4'd0, 1'b1});
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (shadow_used[i]) begin
                            b = '{STAT_OK, shadow_id[i], 4'(i), (i == top)};
                            owed_beats.push_back(b);
                        end
                    end
                end
            end
        endcase
    endtask

    // Queue one command; track the id counter so later lookups can hit
    task automatic push_cmd(input cmd_t op, input logic [15:0] key,
                            input int unsigned gap, input bit drain);
        cmd_item_t c;
        c.op = op;
        c.id = key;
        c.gap = gap;
        c.drain = drain;
        cmd_queue.push_back(c);
        if (op == CMD_CREATE) gen_ctr = gen_ctr + 16'd1;
    endtask

    // Driver: present queued commands with random gaps, hold a beat until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= CMD_CREATE;
            idle_left <= 0;
            gap_taken <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the beat
        end else if (idle_left != 0) begin
            s_tvalid <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (cmd_queue.size() != 0) begin
            nxt = cmd_queue[0];
            if (nxt.drain && (s_tvalid || !all_answered)) begin
                s_tvalid <= 1'b0;
            end else if (nxt.gap != 0 && !gap_taken) begin
                s_tvalid <= 1'b0;
                idle_left <= nxt.gap - 1;
                gap_taken <= 1'b1;
            end else begin
                void'(cmd_queue.pop_front());
                s_tvalid <= 1'b1;
                s_tdata <= nxt.id;
                s_tuser <= nxt.op;
                gap_taken <= 1'b0;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Monitor: check result beats, stall the result side, predict on each command beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_left <= 0;
            all_answered <= 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                shadow_used[i] = 1'b0;
                shadow_id[i] = '0;
            end
            serial_ctr = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.rid = m_tdata[15:0];
                got.slot = m_tdata[19:16];
                got.last = m_tlast;
                beats_seen++;
                if (owed_beats.size() == 0) begin
                    faults++;
                    if (faults <= 30)
                        $display("%0t: unexpected beat status=%0d id=%0d slot=%0d last=%0b",
                                 $time, m_tuser, got.rid, got.slot, got.last);
                end else begin
                    want = owed_beats.pop_front();
                    if (m_tuser !== want.status || got.rid !== want.rid ||
                        got.slot !== want.slot || got.last !== want.last) begin
                        faults++;
                        if (faults <= 30)
                            $display("%0t: mismatch expected status=%0d id=%0d slot=%0d last=%0b %s",
                                     $time, want.status, want.rid, want.slot, want.last,
                                     $sformatf("actual status=%0d id=%0d slot=%0d last=%0b",
                                               m_tuser, got.rid, got.slot, got.last));
                    end
                end
                // switch between stalling and free-running stretches
                if (beats_seen % 32 == 0) rx_idle_on = 1'($urandom_range(0, 1));
                rx_left <= rx_idle_on ? $urandom_range(0, 4) : 0;
                if (rx_idle_on) m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (rx_left == 0) m_tready <= 1'b1;
                else rx_left <= rx_left - 1;
            end
            if (s_tvalid && s_tready) begin
                cmd_seen[s_tuser]++;
                table_apply(cmd_t'(s_tuser), s_tdata);
            end
            all_answered <= (owed_beats.size() == 0);
        end
    end

    // Stimulus and end of run
    initial begin
        // directed: empty table, misses, fill, overflow, list, find, destroy
        push_cmd(CMD_LIST, 16'h0000, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_DESTROY, 16'h0005, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_FIND, 16'h0000, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_FIND, 16'hFFFF, $urandom_range(0, 4), 1'b0);
        for (int i = 0; i < SLOTS; i++) push_cmd(CMD_CREATE, 16'hA5A5, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_CREATE, 16'h0000, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_LIST, 16'hFFFF, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_FIND, 16'd12, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_DESTROY, 16'd1, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_FIND, 16'd1, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_CREATE, 16'h0000, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_LIST, 16'h0000, $urandom_range(0, 4), 1'b0);

        // wait for every result, then free three slots and refill them
        push_cmd(CMD_CREATE, 16'($urandom_range(0, 65535)), 0, 1'b1);
        push_cmd(CMD_DESTROY, 16'd3, 1, 1'b1);
        push_cmd(CMD_DESTROY, 16'd4, 0, 1'b0);
        push_cmd(CMD_DESTROY, 16'd5, 0, 1'b0);
        for (int i = 0; i < 3; i++) push_cmd(CMD_CREATE, 16'h0000, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_FIND, 16'd2, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_DESTROY, 16'd2, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_FIND, 16'd2, $urandom_range(0, 4), 1'b0);
        push_cmd(CMD_LIST, 16'd0, $urandom_range(0, 4), 1'b0);

        // random: lookups mostly aim at recently issued ids, the rest is noise
        burst_mode = 1'b0;
        for (int n = 0; n < 320; n++) begin
            if (n % 40 == 0) burst_mode = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            push_cmd(pick < 35 ? CMD_CREATE : pick < 60 ? CMD_DESTROY :
                     pick < 80 ? CMD_FIND : CMD_LIST,
                     ($urandom_range(0, 3) != 0) ? gen_ctr - 16'($urandom_range(0, 24))
                                                 : 16'($urandom_range(0, 65535)),
                     burst_mode ? 0 : $urandom_range(0, 4), n == 180);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (owed_beats.size() != 0) @(posedge aclk);
        repeat (2 * SLOTS + 8) @(posedge aclk);

        $display("Commands: %0d create, %0d destroy, %0d find, %0d list; %0d result beats checked.",
                 cmd_seen[CMD_CREATE], cmd_seen[CMD_DESTROY], cmd_seen[CMD_FIND],
                 cmd_seen[CMD_LIST], beats_seen);
        $display("Covered full table, empty list, lookup misses and slot reuse under stalls.");
        if (faults == 0) begin
            $display("task_slot_table_core verification clean");
        end else begin
            $display("task_slot_table_core verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("Timeout with %0d commands pending and %0d beats owed.",
                 cmd_queue.size(), owed_beats.size());
        $display("task_slot_table_core verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tst_pkg.sv
rtl/task_slot_table_core.sv
tb/task_slot_table_core_test.sv
